// ===== hdl/imufd_pkg.sv =====
// Shared types and constants of the serial inertial sensor frame decoder.
package imufd_pkg;

   localparam int unsigned FRAME_BYTES = 11;
   localparam int unsigned STORE_DEPTH = FRAME_BYTES - 2;
   localparam int unsigned COUNT_W     = 4;
   localparam int unsigned STORE_IDX_W = 4;
   localparam int unsigned AXIS_W      = 20;
   localparam int unsigned TEMP_W      = 17;
   localparam int unsigned PROD_W      = 24;
   localparam int unsigned TPROD_W     = 49;

   localparam logic [7:0] HEADER_BYTE = 8'h55;
   localparam logic [7:0] TYPE_ACCEL  = 8'h51;
   localparam logic [7:0] TYPE_RATE   = 8'h52;
   localparam logic [7:0] TYPE_ANGLE  = 8'h53;

   // Axis scale factors: round(r*num/2^shift)
   localparam logic signed [PROD_W-1:0] ACCEL_NUM = 24'sd1;
   localparam logic signed [PROD_W-1:0] RATE_NUM  = 24'sd125;
   localparam logic signed [PROD_W-1:0] ANGLE_NUM = 24'sd45;

   // Temperature: floor((128*t + 85)/170) + 9280, with dividend made positive.
   // TEMP_BIAS = 85 + 170*24676; quotient corrected by 24676 - 9280.
   localparam logic signed [24:0]  TEMP_BIAS   = 25'sd4195005;
   localparam logic [TPROD_W-1:0]  TEMP_RECIP  = 49'd25264515;
   localparam logic [TEMP_W-1:0]   TEMP_CORR   = 17'd15396;

   typedef enum logic [1:0] {
      KIND_ACCEL = 2'd0,
      KIND_RATE  = 2'd1,
      KIND_ANGLE = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] x_raw;
      logic signed [15:0] y_raw;
      logic signed [15:0] z_raw;
      logic signed [15:0] t_raw;
   } job_type;

endpackage

// ===== hdl/imufd_front.sv =====
// Frame sync, byte collection and frame classification.
module imufd_front import imufd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   output logic       push,
   output job_type    job
);

   logic [COUNT_W-1:0]     byte_count_ff, byte_count_in;
   logic [7:0]             frame_store_ff [STORE_DEPTH];
   logic [COUNT_W-1:0]     pos;
   logic [STORE_IDX_W-1:0] wr_idx;
   logic                   wr_en;
   logic                   last_byte;
   logic                   type_known;
   kind_type               kind;

   always_comb begin
      pos = (byte_count_ff >= COUNT_W'(FRAME_BYTES)) ? '0 : byte_count_ff;
      wr_idx = STORE_IDX_W'(pos - COUNT_W'(1));
      wr_en = accept && (pos != '0) && (pos <= COUNT_W'(STORE_DEPTH));
      last_byte = (pos == COUNT_W'(FRAME_BYTES - 1));
      byte_count_in = byte_count_ff;
      if (accept) begin
         if (pos == '0) begin
            byte_count_in = (rx_byte == HEADER_BYTE) ? COUNT_W'(1) : '0;
         end else if (last_byte) begin
            byte_count_in = '0;
         end else begin
            byte_count_in = pos + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      type_known = 1'b1;
      kind = KIND_ACCEL;
      unique case (frame_store_ff[0])
         TYPE_ACCEL: kind = KIND_ACCEL;
         TYPE_RATE:  kind = KIND_RATE;
         TYPE_ANGLE: kind = KIND_ANGLE;
         default:    type_known = 1'b0;
      endcase
   end

   // The checksum byte is the last one; all stored entries are filled by then.
   assign push      = accept && last_byte && type_known;
   assign job.kind  = kind;
   assign job.x_raw = {frame_store_ff[2], frame_store_ff[1]};
   assign job.y_raw = {frame_store_ff[4], frame_store_ff[3]};
   assign job.z_raw = {frame_store_ff[6], frame_store_ff[5]};
   assign job.t_raw = {frame_store_ff[8], frame_store_ff[7]};

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (wr_en && (wr_idx == STORE_IDX_W'(i))) begin
            frame_store_ff[i] <= rx_byte;
         end
      end
   end

endmodule

// ===== hdl/imufd_queue.sv =====
// Two-entry frame queue between the collector and the scaler.
module imufd_queue import imufd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    not_empty,
   output logic    full,
   output job_type pop_job
);

   job_type     entry_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;

   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop_job   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hdl/imufd_back.sv =====
// Two-stage scaler: multiply, then round and drive the result register.
module imufd_back import imufd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     job_valid,
   input  job_type                  job,
   output logic                     job_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output kind_type                 rsp_kind,
   output logic signed [AXIS_W-1:0] rsp_x,
   output logic signed [AXIS_W-1:0] rsp_y,
   output logic signed [AXIS_W-1:0] rsp_z,
   output logic signed [TEMP_W-1:0] rsp_t
);

   // Stage 1: products
   logic                     s1_valid_ff;
   kind_type                 s1_kind_ff;
   logic signed [PROD_W-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic [TEMP_W-1:0]        s1_q_ff;

   // Stage 2: result register
   logic                     out_valid_ff;
   kind_type                 out_kind_ff;
   logic signed [AXIS_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic signed [TEMP_W-1:0] out_t_ff;

   logic                     s2_load, s1_load;
   logic signed [PROD_W-1:0] num;
   logic signed [PROD_W-1:0] x_prod_in, y_prod_in, z_prod_in;
   logic signed [24:0]       t_dividend;
   logic [TPROD_W-1:0]       t_prod;
   logic signed [PROD_W-1:0] half;
   logic [2:0]               shift;
   logic signed [PROD_W-1:0] x_rnd, y_rnd, z_rnd;

   assign s2_load = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign s1_load = !s1_valid_ff || s2_load;
   assign job_pop = job_valid && s1_load;

   always_comb begin
      unique case (job.kind)
         KIND_ACCEL: num = ACCEL_NUM;
         KIND_RATE:  num = RATE_NUM;
         KIND_ANGLE: num = ANGLE_NUM;
         default:    num = ACCEL_NUM;
      endcase
      x_prod_in  = PROD_W'(job.x_raw) * num;
      y_prod_in  = PROD_W'(job.y_raw) * num;
      z_prod_in  = PROD_W'(job.z_raw) * num;
      // Dividend stays non-negative, so the reciprocal multiply gives the floor.
      t_dividend = (25'(job.t_raw) <<< 7) + TEMP_BIAS;
      t_prod     = TPROD_W'(t_dividend[23:0]) * TEMP_RECIP;
   end

   always_comb begin
      unique case (s1_kind_ff)
         KIND_ACCEL: begin
            half  = 24'sd4;
            shift = 3'd3;
         end
         KIND_RATE: begin
            half  = 24'sd4;
            shift = 3'd3;
         end
         KIND_ANGLE: begin
            half  = 24'sd16;
            shift = 3'd5;
         end
         default: begin
            half  = 24'sd4;
            shift = 3'd3;
         end
      endcase
      x_rnd = (s1_x_ff + half) >>> shift;
      y_rnd = (s1_y_ff + half) >>> shift;
      z_rnd = (s1_z_ff + half) >>> shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= job_valid;
         end
         if (s2_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         s1_kind_ff <= job.kind;
         s1_x_ff    <= x_prod_in;
         s1_y_ff    <= y_prod_in;
         s1_z_ff    <= z_prod_in;
         s1_q_ff    <= t_prod[TPROD_W-1:32];
      end
      if (s2_load) begin
         out_kind_ff <= s1_kind_ff;
         out_x_ff    <= x_rnd[AXIS_W-1:0];
         out_y_ff    <= y_rnd[AXIS_W-1:0];
         out_z_ff    <= z_rnd[AXIS_W-1:0];
         out_t_ff    <= signed'(s1_q_ff - TEMP_CORR);
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_x     = out_x_ff;
   assign rsp_y     = out_y_ff;
   assign rsp_z     = out_z_ff;
   assign rsp_t     = out_t_ff;

endmodule

// ===== hdl/imu_serial_frame_decoder.sv =====
// Top level of the serial inertial sensor frame decoder.
// Takes one received byte per cycle (req_stall rises only when both queue
// entries hold decoded frames not yet scaled). Bytes are dropped until the
// header 0x55; the next ten bytes complete an eleven-byte frame, and type 0x51,
// 0x52 or 0x53 yields one result of Q.8 axis values and temperature, while any
// other type yields none; the checksum is not checked. rsp_valid rises once the
// frame's result reaches the result register: the queue entry is written at the
// edge that transfers the frame's last byte, then the multiply stage and the
// rounding stage load into the result register. The scaler takes a new frame
// every cycle while the result side does not stall.
module imu_serial_frame_decoder import imufd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_rx_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_packet_kind,
   output logic signed [AXIS_W-1:0] rsp_x_value,
   output logic signed [AXIS_W-1:0] rsp_y_value,
   output logic signed [AXIS_W-1:0] rsp_z_value,
   output logic signed [TEMP_W-1:0] rsp_temperature
);

   logic     accept;
   logic     push, pop, not_empty, full;
   job_type  push_job, pop_job;
   kind_type rsp_kind;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   imufd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .push    (push),
      .job     (push_job)
   );

   imufd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .not_empty (not_empty),
      .full      (full),
      .pop_job   (pop_job)
   );

   imufd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (not_empty),
      .job       (pop_job),
      .job_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_kind  (rsp_kind),
      .rsp_x     (rsp_x_value),
      .rsp_y     (rsp_y_value),
      .rsp_z     (rsp_z_value),
      .rsp_t     (rsp_temperature)
   );

   assign rsp_packet_kind = rsp_kind;

endmodule

// ===== hdl/imufd_checker.sv =====
// Port-level assertions for the frame decoder, bound to the top level.
module imufd_checker import imufd_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [1:0]               rsp_packet_kind,
   input logic signed [AXIS_W-1:0] rsp_x_value,
   input logic signed [TEMP_W-1:0] rsp_temperature
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_x_value)
         && $stable(rsp_temperature) && $stable(rsp_packet_kind))
      else $error("stalled result changed");

   // Reset empties the pipeline.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall after reset");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temperature >= -17'sd15396 && rsp_temperature <= 17'sd33952)
      else $error("temperature out of range");

   a_accel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_kind == KIND_ACCEL
         |-> rsp_x_value >= -20'sd4096 && rsp_x_value <= 20'sd4096)
      else $error("acceleration out of range");

endmodule

bind imu_serial_frame_decoder imufd_checker u_imufd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_packet_kind (rsp_packet_kind),
   .rsp_x_value     (rsp_x_value),
   .rsp_temperature (rsp_temperature)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench of the serial inertial sensor frame decoder: stimulus, prediction, checks.
module tb;
   import imufd_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_BYTES  = 1200;
   localparam int DRAIN_CYCLES  = 20;

   typedef struct {
      kind_type                 kind;
      logic signed [AXIS_W-1:0] x_value;
      logic signed [AXIS_W-1:0] y_value;
      logic signed [AXIS_W-1:0] z_value;
      logic signed [TEMP_W-1:0] temperature;
   } scaled_frame_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [7:0]               req_rx_byte;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [1:0]               rsp_packet_kind;
   logic signed [AXIS_W-1:0] rsp_x_value;
   logic signed [AXIS_W-1:0] rsp_y_value;
   logic signed [AXIS_W-1:0] rsp_z_value;
   logic signed [TEMP_W-1:0] rsp_temperature;

   // Predictor state
   int               frame_pos;
   logic [7:0]       frame_bytes [STORE_DEPTH];
   scaled_frame_type scaled_frames_q [$];
   int               framed_bytes;

   int               error_count;
   int               cycle_count;
   bit               idle_on;
   bit               long_hold_req;
   int               stall_left;
   scaled_frame_type head;

   imu_serial_frame_decoder i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packet_kind (rsp_packet_kind),
      .rsp_x_value     (rsp_x_value),
      .rsp_y_value     (rsp_y_value),
      .rsp_z_value     (rsp_z_value),
      .rsp_temperature (rsp_temperature)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Nearest integer of raw*num/den, ties toward plus infinity.
   function automatic longint round_ratio(input longint raw, input longint num,
                                          input longint den);
      longint n;
      longint d;
      n = 2 * raw * num + den;
      d = 2 * den;
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   function automatic logic signed [15:0] frame_word(input int lo);
      return {frame_bytes[lo + 1], frame_bytes[lo]};
   endfunction

   task automatic decode_frame_byte(input logic [7:0] b);
      scaled_frame_type r;
      longint           num;
      longint           den;
      longint           v;
      bit               known;
      if (frame_pos == 0 || frame_pos >= FRAME_BYTES) begin
         frame_pos = (b == HEADER_BYTE) ? 1 : 0;
         if (frame_pos == 1) framed_bytes++;
      end else begin
         framed_bytes++;
         if (frame_pos <= STORE_DEPTH) frame_bytes[frame_pos - 1] = b;
         if (frame_pos + 1 < FRAME_BYTES) begin
            frame_pos++;
         end else begin
            frame_pos = 0;
            known = 1'b1;
            num = 1;
            den = 8;
            r.kind = KIND_ACCEL;
            case (frame_bytes[0])
               TYPE_ACCEL: begin
                  r.kind = KIND_ACCEL; num = 1; den = 8;
               end
               TYPE_RATE: begin
                  r.kind = KIND_RATE; num = 125; den = 8;
               end
               TYPE_ANGLE: begin
                  r.kind = KIND_ANGLE; num = 45; den = 32;
               end
               default: known = 1'b0;
            endcase
            if (known) begin
               v = round_ratio(frame_word(1), num, den);
               r.x_value = v[AXIS_W-1:0];
               v = round_ratio(frame_word(3), num, den);
               r.y_value = v[AXIS_W-1:0];
               v = round_ratio(frame_word(5), num, den);
               r.z_value = v[AXIS_W-1:0];
               v = round_ratio(frame_word(7), 64, 85) + 9280;
               r.temperature = v[TEMP_W-1:0];
               scaled_frames_q.push_back(r);
            end
         end
      end
   endtask

   // Offer one byte at the falling edge, hold it until the transfer.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      decode_frame_byte(b);
   endtask

   task automatic send_frame(input logic [7:0] kind_byte, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z,
                             input logic [15:0] t, input logic [7:0] csum);
      send_byte(HEADER_BYTE);
      send_byte(kind_byte);
      send_byte(x[7:0]);
      send_byte(x[15:8]);
      send_byte(y[7:0]);
      send_byte(y[15:8]);
      send_byte(z[7:0]);
      send_byte(z[15:8]);
      send_byte(t[7:0]);
      send_byte(t[15:8]);
      send_byte(csum);
   endtask

   function automatic logic [15:0] pick_word();
      logic [15:0] w;
      case ($urandom_range(0, 7))
         0:       w = 16'h8000;
         1:       w = 16'h7fff;
         2:       w = 16'h0000;
         3:       w = 16'($urandom_range(0, 32) - 16);
         default: w = 16'($urandom);
      endcase
      return w;
   endfunction

   function automatic logic [7:0] pick_kind();
      logic [7:0] k;
      case ($urandom_range(0, 9))
         0, 1, 2: k = TYPE_ACCEL;
         3, 4, 5: k = TYPE_RATE;
         6, 7, 8: k = TYPE_ANGLE;
         default: k = 8'($urandom);
      endcase
      return k;
   endfunction

   task automatic send_random_frame();
      send_frame(pick_kind(), pick_word(), pick_word(), pick_word(), pick_word(),
                 8'($urandom));
   endtask

   task automatic check_field(input string name, input longint exp_v,
                              input longint act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // Sample each result transfer at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (scaled_frames_q.size() == 0) begin
            $display("%0t: result with none expected, actual kind %0d x %0d", $time,
                     rsp_packet_kind, rsp_x_value);
            error_count++;
         end else begin
            head = scaled_frames_q.pop_front();
            check_field("packet_kind", longint'(head.kind), longint'(rsp_packet_kind));
            check_field("x_value", head.x_value, rsp_x_value);
            check_field("y_value", head.y_value, rsp_y_value);
            check_field("z_value", head.z_value, rsp_z_value);
            check_field("temperature", head.temperature, rsp_temperature);
         end
      end
   end

   // Result side stall: random bursts, or one long hold on request.
   always @(negedge clock) begin
      if (long_hold_req) begin
         stall_left = LONG_HOLD;
         long_hold_req = 1'b0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 15);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   task automatic test_directed();
      idle_on = 1'b1;
      // drop noise while idle
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h54);
      // axis extremes and rounding ties
      send_frame(TYPE_ACCEL, 16'h8000, 16'h7fff, 16'h0004, 16'h8000, 8'h00);
      send_frame(TYPE_RATE, 16'h7fff, 16'h8000, 16'hfffc, 16'h7fff, 8'hff);
      send_frame(TYPE_ANGLE, 16'h0010, 16'hfff0, 16'h8000, 16'h0000, 8'h55);
      // unknown types, and header bytes inside the frames
      send_frame(8'h54, 16'h5555, 16'h0055, 16'h5500, 16'h5555, 8'h55);
      send_frame(HEADER_BYTE, 16'hffff, 16'h0001, 16'h1234, 16'hfedc, 8'h00);
      send_frame(TYPE_ACCEL, 16'hfff4, 16'h5555, 16'hfffc, 16'h5555, 8'h55);
   endtask

   task automatic test_random();
      int start_count;
      int frames;
      int n;
      start_count = framed_bytes;
      frames = 0;
      while (framed_bytes - start_count < RANDOM_BYTES) begin
         // alternate stretches with and without idling
         idle_on = ((frames / 16) % 4) != 3;
         case ($urandom_range(0, 9))
            0, 1: begin
               n = $urandom_range(1, 4);
               repeat (n) send_byte(8'($urandom));
            end
            2: begin
               // truncated frame, the next header is taken as data
               send_byte(HEADER_BYTE);
               n = $urandom_range(1, 9);
               repeat (n) send_byte(8'($urandom));
            end
            default: ;
         endcase
         send_random_frame();
         frames++;
      end
   endtask

   task automatic test_backpressure();
      idle_on = 1'b0;
      @(negedge clock);
      long_hold_req = 1'b1;
      repeat (30) send_random_frame();
   endtask

   task automatic test_quiet_tail();
      idle_on = 1'b0;
      repeat (15) send_random_frame();
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_rx_byte   = 8'h00;
      rsp_stall     = 1'b0;
      frame_pos     = 0;
      framed_bytes  = 0;
      error_count   = 0;
      cycle_count   = 0;
      idle_on       = 1'b0;
      long_hold_req = 1'b0;
      stall_left    = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random();
      test_backpressure();
      test_quiet_tail();

      @(negedge clock);
      req_valid <= 1'b0;
      while (scaled_frames_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && scaled_frames_q.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
